[src/assert_macros.svh]
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/mtd_pkg.sv]
// shared types, constants and character helpers for the mime transfer decoder
package mtd_pkg;

    // decode modes
    localparam logic [1:0] MODE_PASS = 2'd0;
    localparam logic [1:0] MODE_QP   = 2'd1;
    localparam logic [1:0] MODE_B64  = 2'd2;

    // special characters
    localparam logic [7:0] CH_EQ = 8'h3D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    localparam int MAX_RES = 4;

    // quoted-printable escape phase
    typedef enum logic [3:0] {
        ESC_IDLE = 4'b0001,
        ESC_EQ   = 4'b0010,
        ESC_HEX  = 4'b0100,
        ESC_CR   = 4'b1000
    } esc_t;

    // one result
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       part_end;
    } mtd_res_t;

    // all results of one input transaction
    typedef struct packed {
        mtd_res_t [MAX_RES-1:0] res;
        logic [2:0]             count;
    } mtd_list_t;

    function automatic mtd_res_t mtd_res_byte(input logic [7:0] b);
        mtd_res_t r;
        r.out_byte   = b;
        r.byte_valid = 1'b1;
        r.part_end   = 1'b0;
        return r;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if (c >= 8'h30 && c <= 8'h39)
            v = c - 8'h30;
        else if (c >= 8'h41 && c <= 8'h46)
            v = c - 8'h37;
        else if (c >= 8'h61 && c <= 8'h66)
            v = c - 8'h57;
        else
            v = 8'h00;
        return v[3:0];
    endfunction

    // returns {valid, 6-bit value}
    function automatic logic [6:0] b64_val(input logic [7:0] c);
        logic [7:0] v;
        logic       ok;
        ok = 1'b1;
        if (c >= 8'h41 && c <= 8'h5A)
            v = c - 8'h41;
        else if (c >= 8'h61 && c <= 8'h7A)
            v = c - 8'h47;
        else if (c >= 8'h30 && c <= 8'h39)
            v = c + 8'h04;
        else if (c == 8'h2B)
            v = 8'd62;
        else if (c == 8'h2F)
            v = 8'd63;
        else
        begin
            v  = 8'h00;
            ok = 1'b0;
        end
        return {ok, v[5:0]};
    endfunction

endpackage

[src/mtd_decode.sv]
// decode state and single-pass decode of one byte into a result list
module mtd_decode (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        mode,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    input  logic              accept,
    output mtd_pkg::mtd_list_t res_list
);
    import mtd_pkg::*;

    esc_t        esc_reg, esc_next;
    logic [7:0]  held_reg, held_next;
    logic [11:0] acc_reg, acc_next;
    logic [2:0]  bits_reg, bits_next;
    logic        pad_reg, pad_next;

    mtd_list_t   lst;
    logic        do_idle;
    logic [6:0]  b64;
    logic [3:0]  bit_sum;
    logic [11:0] shifted;

    // decode one byte, building the ordered result list
    always_comb
    begin
        lst       = '0;
        esc_next  = esc_reg;
        held_next = held_reg;
        acc_next  = acc_reg;
        bits_next = bits_reg;
        pad_next  = pad_reg;
        do_idle   = 1'b0;
        b64       = b64_val(data_byte);
        bit_sum   = {1'b0, bits_reg} + 4'd6;
        shifted   = '0;

        if (mode == MODE_QP)
        begin
            case (esc_reg)
                ESC_IDLE:
                begin
                    do_idle = 1'b1;
                end
                ESC_EQ:
                begin
                    if (data_byte == CH_LF)
                        esc_next = ESC_IDLE;
                    else if (data_byte == CH_CR)
                    begin
                        esc_next  = ESC_CR;
                        held_next = CH_CR;
                    end
                    else if (is_hex(data_byte))
                    begin
                        esc_next  = ESC_HEX;
                        held_next = data_byte;
                    end
                    else
                    begin
                        esc_next = ESC_IDLE;
                        lst.res[lst.count[1:0]] = mtd_res_byte(CH_EQ);
                        lst.count = lst.count + 3'd1;
                        do_idle = 1'b1;
                    end
                end
                ESC_HEX:
                begin
                    esc_next = ESC_IDLE;
                    if (is_hex(data_byte))
                    begin
                        lst.res[lst.count[1:0]] =
                            mtd_res_byte({hex_val(held_reg), hex_val(data_byte)});
                        lst.count = lst.count + 3'd1;
                    end
                    else
                    begin
                        lst.res[lst.count[1:0]] = mtd_res_byte(CH_EQ);
                        lst.count = lst.count + 3'd1;
                        lst.res[lst.count[1:0]] = mtd_res_byte(held_reg);
                        lst.count = lst.count + 3'd1;
                        do_idle = 1'b1;
                    end
                end
                ESC_CR:
                begin
                    esc_next = ESC_IDLE;
                    if (data_byte != CH_LF)
                    begin
                        lst.res[lst.count[1:0]] = mtd_res_byte(CH_EQ);
                        lst.count = lst.count + 3'd1;
                        lst.res[lst.count[1:0]] = mtd_res_byte(CH_CR);
                        lst.count = lst.count + 3'd1;
                        do_idle = 1'b1;
                    end
                end
                default:
                begin
                    esc_next = ESC_IDLE;
                end
            endcase

            // byte seen from the idle phase
            if (do_idle)
            begin
                if (data_byte == CH_EQ)
                    esc_next = ESC_EQ;
                else
                begin
                    lst.res[lst.count[1:0]] = mtd_res_byte(data_byte);
                    lst.count = lst.count + 3'd1;
                end
            end
        end
        else if (mode == MODE_B64)
        begin
            if (!pad_reg)
            begin
                if (data_byte == CH_EQ)
                    pad_next = 1'b1;
                else if (b64[6])
                begin
                    acc_next = {acc_reg[5:0], b64[5:0]};
                    if (bit_sum >= 4'd8)
                    begin
                        bits_next = 3'(bit_sum - 4'd8);
                        shifted   = acc_next >> bits_next;
                        lst.res[lst.count[1:0]] = mtd_res_byte(shifted[7:0]);
                        lst.count = lst.count + 3'd1;
                    end
                    else
                        bits_next = bit_sum[2:0];
                end
            end
        end
        else
        begin
            lst.res[lst.count[1:0]] = mtd_res_byte(data_byte);
            lst.count = lst.count + 3'd1;
        end

        // part end: flush a pending escape, clear state, add end marker
        if (last_byte)
        begin
            if (mode == MODE_QP && esc_next != ESC_IDLE)
            begin
                lst.res[lst.count[1:0]] = mtd_res_byte(CH_EQ);
                lst.count = lst.count + 3'd1;
                if (esc_next == ESC_HEX || esc_next == ESC_CR)
                begin
                    lst.res[lst.count[1:0]] = mtd_res_byte(held_next);
                    lst.count = lst.count + 3'd1;
                end
            end
            esc_next  = ESC_IDLE;
            held_next = '0;
            acc_next  = '0;
            bits_next = '0;
            pad_next  = 1'b0;
            lst.res[lst.count[1:0]].out_byte   = '0;
            lst.res[lst.count[1:0]].byte_valid = 1'b0;
            lst.res[lst.count[1:0]].part_end   = 1'b1;
            lst.count = lst.count + 3'd1;
        end
    end

    assign res_list = lst;

    // decode state, updated on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg  <= ESC_IDLE;
            held_reg <= '0;
            acc_reg  <= '0;
            bits_reg <= '0;
            pad_reg  <= 1'b0;
        end
        else if (accept)
        begin
            esc_reg  <= esc_next;
            held_reg <= held_next;
            acc_reg  <= acc_next;
            bits_reg <= bits_next;
            pad_reg  <= pad_next;
        end
    end

endmodule

[src/mtd_serializer.sv]
// result register that holds one result list and sends it one result per cycle while out_stall is low
module mtd_serializer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  mtd_pkg::mtd_list_t res_list,
    output logic              can_load,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        out_byte,
    output logic              byte_valid,
    output logic              run_last,
    output logic              part_end
);
    import mtd_pkg::*;

    mtd_list_t  buf_reg;
    logic [1:0] idx_reg;
    logic       valid_reg;
    logic       is_last;
    logic       out_take;
    mtd_res_t   cur;

    // current result and its position in the list
    assign cur      = buf_reg.res[idx_reg];
    assign is_last  = ({1'b0, idx_reg} == (buf_reg.count - 3'd1));
    assign out_take = valid_reg && !out_stall;
    assign can_load = !valid_reg || (out_take && is_last);

    assign out_valid  = valid_reg;
    assign out_byte   = cur.out_byte;
    assign byte_valid = cur.byte_valid;
    assign part_end   = cur.part_end;
    assign run_last   = is_last;

    // list payload
    always_ff @(posedge clk)
    begin
        if (load && can_load)
            buf_reg <= res_list;
    end

    // read pointer and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load && can_load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (out_take)
        begin
            if (is_last)
                valid_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 2'd1;
        end
    end

endmodule

[src/mime_transfer_decoder.sv]
// mime transfer decoder top level: pass-through, quoted-printable and base64
// the first result of a transaction is registered and appears in the cycle after it is accepted
// throughput: one byte per cycle while each byte yields at most one result and out_stall is low;
//   a byte that yields more results (up to four) holds the input until its last result is taken,
//   because the result register sends one result per cycle while out_stall is low
// reset: mode returns to pass-through, decode state clears and the result register empties
module mime_transfer_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       run_last,
    output logic       part_end
);
    import mtd_pkg::*;

    `include "assert_macros.svh"

    logic [1:0] mode_reg;
    mtd_list_t  res_list;
    logic       can_load;
    logic       in_accept;

    // mode register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_PASS;
        else if (cfg_valid && cfg_ready)
            mode_reg <= cfg_data;
    end

    // input handshake
    assign in_stall  = !can_load;
    assign in_accept = in_valid && !in_stall;

    mtd_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (mode_reg),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .accept    (in_accept),
        .res_list  (res_list)
    );

    mtd_serializer u_serializer (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (in_accept && (res_list.count != 3'd0)),
        .res_list   (res_list),
        .can_load   (can_load),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .run_last   (run_last),
        .part_end   (part_end)
    );

    // checks
    `ASSERT_NOW(a_end_marker_closes, out_valid && part_end, run_last && !byte_valid)
    `ASSERT_NOW(a_accept_only_when_free, in_valid && !in_stall,
                !out_valid || (!out_stall && run_last))
    `ASSERT_NEXT(a_list_continues, out_valid && !out_stall && !run_last, out_valid)
    `ASSERT_NEXT(a_end_after_last, in_valid && !in_stall && last_byte, out_valid)

endmodule
